[hdl/wrc_pkg.sv]
// shared types and constants for the weighted reno window control block
// no dependencies

package wrc_pkg;

   localparam int WIN_W      = 32;
   localparam int MSS_W      = 16;
   localparam int WGT_W      = 8;
   localparam int ACK_W      = 16;
   localparam int NUM_W      = 2 * MSS_W + WGT_W;
   localparam int DIV_STEPS  = NUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W = 3;

   localparam logic [WIN_W-1:0] WIN_MAX          = '1;
   localparam logic [WIN_W-1:0] WINDOW_RESET     = 32'd5360;
   localparam logic [WIN_W-1:0] THRESHOLD_RESET  = '1;
   localparam logic [MSS_W-1:0] MSS_RESET        = 16'd536;
   localparam logic [WGT_W-1:0] WEIGHT_RESET     = 8'd1;

   localparam logic [1:0] REQ_ACK  = 2'd0;
   localparam logic [1:0] REQ_LOSS = 2'd1;
   localparam logic [1:0] REQ_LOAD = 2'd2;

   localparam logic REG_SEGMENT_SIZE = 1'b0;
   localparam logic REG_FLOW_WEIGHT  = 1'b1;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

[hdl/weighted_reno_window_control.sv]
// congestion window and slow-start threshold with weighted additive increase
// depends on wrc_pkg and wrc_div
//
//  channel  dir  handshake          payload
//  req      in   req_valid/ready    req_type, req_segments_acked, req_bytes_in_flight,
//                                   req_load_cwnd, req_load_ssthresh
//  rsp      out  rsp_valid/ready    rsp_cwnd_bytes, rsp_ssthresh_bytes
//  csr      in   psel/penable       paddr, pwdata, prdata, pready
//
// loss, load and unused codes: accept in idle, then finish
// ack without avoidance increase: idle, check, finish; with it also mul1, mul2,
// div and add, where the 40 step restoring divider runs (one quotient bit per cycle)
// one word in flight; req_ready only in idle, a waiting result word holds the next in finish
// synchronous active high reset, no clearing pass

module weighted_reno_window_control
   import wrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [ACK_W-1:0]      req_segments_acked,
   input  logic [WIN_W-1:0]      req_bytes_in_flight,
   input  logic [WIN_W-1:0]      req_load_cwnd,
   input  logic [WIN_W-1:0]      req_load_ssthresh,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WIN_W-1:0]      rsp_cwnd_bytes,
   output logic [WIN_W-1:0]      rsp_ssthresh_bytes,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_MUL1   = 7'b0000100,
      ST_MUL2   = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_ADD    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [MSS_W-1:0]   mss_ff;
   logic [WGT_W-1:0]   weight_ff;
   logic [WIN_W-1:0]   window_ff, window_in;
   logic [WIN_W-1:0]   thresh_ff, thresh_in;
   logic               acks_rem_ff, acks_rem_in;
   logic [WIN_W-1:0]   sq_ff, sq_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WIN_W-1:0]   rsp_cwnd_ff, rsp_cwnd_in;
   logic [WIN_W-1:0]   rsp_ssthresh_ff, rsp_ssthresh_in;

   div_ctl_type        div_ctl;
   div_sts_type        div_sts;
   logic [NUM_W-1:0]   dividend;
   logic [NUM_W-1:0]   quotient;

   logic               csr_wr;
   logic               csr_idx;
   logic               accept;
   logic [WIN_W:0]     ss_sum;
   logic [WIN_W:0]     ca_sum;
   logic [WIN_W-1:0]   inc;
   logic [WIN_W-1:0]   floor2;
   logic [WIN_W-1:0]   half;

   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[2];
   assign pready  = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_SEGMENT_SIZE: prdata = {16'b0, mss_ff};
         REG_FLOW_WEIGHT:  prdata = {24'b0, weight_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff    <= MSS_RESET;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SEGMENT_SIZE: mss_ff    <= pwdata[MSS_W-1:0];
            REG_FLOW_WEIGHT:  weight_ff <= pwdata[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign dividend  = NUM_W'(sq_ff) * NUM_W'(weight_ff);

   wrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend (dividend),
      .divisor  (window_ff),
      .div_sts  (div_sts),
      .quotient (quotient)
   );

   always_comb begin
      ss_sum = {1'b0, window_ff} + {{(WIN_W+1-MSS_W){1'b0}}, mss_ff};
      inc    = (quotient == '0) ? WIN_W'(1) : quotient[WIN_W-1:0];
      ca_sum = {1'b0, window_ff} + {1'b0, inc};
      floor2 = {{(WIN_W-MSS_W-1){1'b0}}, mss_ff, 1'b0};
      half   = {1'b0, req_bytes_in_flight[WIN_W-1:1]};

      state_in        = state_ff;
      window_in       = window_ff;
      thresh_in       = thresh_ff;
      acks_rem_in     = acks_rem_ff;
      sq_in           = sq_ff;
      div_ctl.start   = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_cwnd_in     = rsp_cwnd_ff;
      rsp_ssthresh_in = rsp_ssthresh_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_ACK: begin
                     state_in = ST_CHECK;
                     if (window_ff < thresh_ff) begin
                        if (req_segments_acked != '0) begin
                           window_in   = ss_sum[WIN_W] ? WIN_MAX : ss_sum[WIN_W-1:0];
                           acks_rem_in = (req_segments_acked != ACK_W'(1));
                        end else begin
                           acks_rem_in = 1'b0;
                        end
                     end else begin
                        acks_rem_in = (req_segments_acked != '0);
                     end
                  end
                  REQ_LOSS: begin
                     state_in  = ST_FINISH;
                     thresh_in = (half > floor2) ? half : floor2;
                  end
                  REQ_LOAD: begin
                     state_in  = ST_FINISH;
                     window_in = req_load_cwnd;
                     thresh_in = req_load_ssthresh;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_CHECK: begin
            if (window_ff >= thresh_ff && acks_rem_ff) begin
               if (window_ff == '0) begin
                  window_in = WIN_MAX;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_MUL1;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL1: begin
            sq_in    = WIN_W'(mss_ff) * WIN_W'(mss_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            div_ctl.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (quotient[NUM_W-1:WIN_W] != '0 || ca_sum[WIN_W]) begin
               window_in = WIN_MAX;
            end else begin
               window_in = ca_sum[WIN_W-1:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_cwnd_in     = window_ff;
               rsp_ssthresh_in = thresh_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         thresh_ff    <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
         acks_rem_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
         acks_rem_ff  <= acks_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff           <= sq_in;
      rsp_cwnd_ff     <= rsp_cwnd_in;
      rsp_ssthresh_ff <= rsp_ssthresh_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cwnd_bytes     = rsp_cwnd_ff;
   assign rsp_ssthresh_bytes = rsp_ssthresh_ff;

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_sts.busy || div_sts.done)
      else $error("waiting on idle divider");

   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV || state_ff == ST_ADD |-> window_ff != '0)
      else $error("divide by zero window");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result word not loaded");

endmodule

[hdl/wrc_div.sv]
// restoring divider, one quotient bit per cycle, shared subtract and compare
// depends on wrc_pkg

module wrc_div
   import wrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       div_ctl,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [WIN_W-1:0]  divisor,
   output div_sts_type       div_sts,
   output logic [NUM_W-1:0]  quotient
);

   logic [WIN_W:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [WIN_W:0]     shifted;
   logic [WIN_W+1:0]   diff;
   logic               ge;

   always_comb begin
      shifted = {rem_ff[WIN_W-1:0], quo_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      ge      = !diff[WIN_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WIN_W:0] : shifted;
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign quotient     = quo_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff && !div_ctl.start |=> !done_ff)
      else $error("divider done held");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < DIV_CNT_W'(DIV_STEPS))
      else $error("divider count out of range");

endmodule
